>>> rtl/base64_encoder_defines.svh
// Assertion helpers shared by the encoder RTL.
`ifndef BASE64_ENCODER_DEFINES_SVH
`define BASE64_ENCODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define B64_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("b64 same-cycle check failed");

// next-cycle implication, disabled during reset
`define B64_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("b64 next-cycle check failed");

`endif

>>> rtl/b64_pkg.sv
`default_nettype none

package b64_pkg;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [6:0] PAD_CHAR = 7'd61;

   typedef struct packed {
      logic [23:0] data;       // first byte in the top bits
      logic [1:0]  pad_count;  // trailing '=' characters
      logic        last;       // group ends the message
   } group_type;

   typedef struct packed {
      logic      valid;
      group_type grp;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] c;
      if (v < 6'd26) begin
         c = 7'd65 + {1'b0, v};
      end else if (v < 6'd52) begin
         c = 7'd71 + {1'b0, v};
      end else if (v < 6'd62) begin
         c = {1'b0, v} - 7'd4;
      end else if (v == 6'd62) begin
         c = 7'd43;
      end else begin
         c = 7'd47;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/b64_front.sv
`default_nettype none

module b64_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,
   input  wire logic             req_tlast,
   input  wire b64_pkg::qstat_type qstat,
   output b64_pkg::push_type     push
);
   import b64_pkg::*;

   logic [1:0] count_ff, count_in;
   logic [7:0] b0_ff, b0_in;
   logic [7:0] b1_ff, b1_in;
   logic       accept;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && !qstat.full;

   always_comb begin
      count_in = count_ff;
      b0_in    = b0_ff;
      b1_in    = b1_ff;
      push     = '0;
      if (accept) begin
         if (count_ff[1]) begin
            push.valid         = 1'b1;
            push.grp.data      = {b0_ff, b1_ff, req_tdata};
            push.grp.pad_count = 2'd0;
            push.grp.last      = req_tlast;
            count_in           = 2'd0;
         end else if (req_tlast) begin
            push.valid    = 1'b1;
            push.grp.last = 1'b1;
            if (count_ff[0]) begin
               push.grp.data      = {b0_ff, req_tdata, 8'h00};
               push.grp.pad_count = 2'd1;
            end else begin
               push.grp.data      = {req_tdata, 16'h0000};
               push.grp.pad_count = 2'd2;
            end
            count_in = 2'd0;
         end else begin
            if (count_ff[0]) begin
               b1_in = req_tdata;
            end else begin
               b0_in = req_tdata;
            end
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      b0_ff <= b0_in;
      b1_ff <= b1_in;
   end

endmodule

`default_nettype wire

>>> rtl/b64_fifo.sv
`default_nettype none
`include "base64_encoder_defines.svh"

module b64_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire b64_pkg::push_type push,
   input  wire logic              pop,
   output b64_pkg::qstat_type     qstat,
   output b64_pkg::group_type     head
);
   import b64_pkg::*;

   group_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] n;
      if (p == QPTR_W'(QDEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + QPTR_W'(1);
      end
      return n;
   endfunction

   assign qstat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push.valid) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.grp;
      end
   end

   `B64_ASSERT_NOW(a_no_push_full, push.valid, !qstat.full)
   `B64_ASSERT_NOW(a_no_pop_empty, pop, !qstat.empty)
   `B64_ASSERT_NEXT(a_push_fills, push.valid && !pop, !qstat.empty)

endmodule

`default_nettype wire

>>> rtl/b64_back.sv
`default_nettype none
`include "base64_encoder_defines.svh"

module b64_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire b64_pkg::qstat_type qstat,
   input  wire b64_pkg::group_type head,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic                    rsp_tlast
);
   import b64_pkg::*;

   group_type  grp_ff, grp_in;
   logic       have_ff, have_in;
   logic [1:0] sel_ff, sel_in;
   logic       oval_ff, oval_in;
   logic [6:0] ochar_ff, ochar_in;
   logic       olast_ff, olast_in;
   logic       load;
   logic [5:0] sextet;
   logic [2:0] pos_sum;

   assign load = have_ff && (!oval_ff || rsp_tready);

   always_comb begin
      case (sel_ff)
         2'd0:    sextet = grp_ff.data[23:18];
         2'd1:    sextet = grp_ff.data[17:12];
         2'd2:    sextet = grp_ff.data[11:6];
         default: sextet = grp_ff.data[5:0];
      endcase
      pos_sum = {1'b0, sel_ff} + {1'b0, grp_ff.pad_count};
   end

   always_comb begin
      grp_in   = grp_ff;
      have_in  = have_ff;
      sel_in   = sel_ff;
      oval_in  = oval_ff && !rsp_tready;
      ochar_in = ochar_ff;
      olast_in = olast_ff;
      if (load) begin
         oval_in  = 1'b1;
         ochar_in = (pos_sum > 3'd3) ? PAD_CHAR : b64_char(sextet);
         olast_in = grp_ff.last && (sel_ff == 2'd3);
         sel_in   = sel_ff + 2'd1;
         if (sel_ff == 2'd3) begin
            have_in = 1'b0;
         end
      end
      pop = (!have_ff || (load && sel_ff == 2'd3)) && !qstat.empty;
      if (pop) begin
         grp_in  = head;
         have_in = 1'b1;
         sel_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         sel_ff  <= 2'd0;
         oval_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
         sel_ff  <= sel_in;
         oval_ff <= oval_in;
      end
      grp_ff   <= grp_in;
      ochar_ff <= ochar_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = oval_ff;
   assign rsp_tdata  = {1'b0, ochar_ff};
   assign rsp_tlast  = olast_ff;

   `B64_ASSERT_NOW(a_sel_needs_group, sel_ff != 2'd0, have_ff)
   `B64_ASSERT_NEXT(a_pop_loads, pop, have_ff && sel_ff == 2'd0)

endmodule

`default_nettype wire

>>> rtl/base64_encoder.sv
// Streaming base64 encoder (standard alphabet, '=' padding).
// Input: one message byte per beat on req_tdata; req_tlast marks the final
// byte of a message. Output: one ASCII character per beat on rsp_tdata[6:0]
// (bit 7 is zero); rsp_tlast marks the final character of the message.
// Every third byte of a group, and any final byte, releases four characters;
// a short final group is zero-filled and padded with one or two '='.
// Structure: a front end gathers bytes into groups, a two-entry group queue
// decouples it from the back end, which emits one character per cycle while
// rsp_tready is high, through a registered output.
// A group's first character passes from the queue entry through the back
// end's group register to the output register. Throughput: the output port
// emits one character per cycle while rsp_tready is high, and every group
// takes four characters whether it carries three bytes or one, so the
// single-character output port limits the sustained input rate.
// Reset clears the front end's byte count, the queue's pointers and count,
// and the output valid flag. When rsp_tready is low the output holds; the
// queue fills and req_tready drops only once two further groups are waiting.
`default_nettype none

module base64_encoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // end_of_message
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [6:0] char_code, [7] zero
   output logic            rsp_tlast    // last_char
);
   import b64_pkg::*;

   push_type  push;
   qstat_type qstat;
   group_type head;
   logic      pop;

   b64_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .qstat      (qstat),
      .push       (push)
   );

   b64_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .qstat (qstat),
      .head  (head)
   );

   b64_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
